// ----- rtl/typed_vector_reduce_combiner_macros.svh -----
// Assertion macros for the reduce combiner.
`ifndef TYPED_VECTOR_REDUCE_COMBINER_MACROS_SVH
`define TYPED_VECTOR_REDUCE_COMBINER_MACROS_SVH

`ifndef SYNTHESIS

`define TVRC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("tvrc assertion failed");

`define TVRC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("tvrc assertion failed");

`else

`define TVRC_ASSERT_IMP(lbl, clk, rst_n, ante, cons)

`define TVRC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ----- rtl/tvrc_pkg.sv -----
`default_nettype none

package tvrc_pkg;

    localparam int WORD_W     = 64;
    localparam int HALF_W     = WORD_W / 2;
    localparam int BYTES      = WORD_W / 8;
    localparam int BYTE_IDX_W = $clog2(BYTES);
    localparam int WORDS      = 256;
    localparam int ADDR_W     = $clog2(WORDS);
    localparam int IDX_W      = 8;
    localparam int OP_W       = 3;
    localparam int TYPE_W     = 3;
    localparam int CNT_W      = 12;
    localparam int WC_W       = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    typedef logic [WORD_W-1:0] t_word;
    typedef logic [7:0]        t_byte;

    // operation codes
    localparam logic [OP_W-1:0] OP_MIN  = 3'd0;
    localparam logic [OP_W-1:0] OP_MAX  = 3'd1;
    localparam logic [OP_W-1:0] OP_SUM  = 3'd2;
    localparam logic [OP_W-1:0] OP_PROD = 3'd3;
    localparam logic [OP_W-1:0] OP_AND  = 3'd4;
    localparam logic [OP_W-1:0] OP_OR   = 3'd5;
    localparam logic [OP_W-1:0] OP_XOR  = 3'd6;

    // lane width codes, elem_type[2:1]
    localparam logic [WC_W-1:0] WC_64 = 2'd0;
    localparam logic [WC_W-1:0] WC_32 = 2'd1;
    localparam logic [WC_W-1:0] WC_16 = 2'd2;
    localparam logic [WC_W-1:0] WC_8  = 2'd3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_OP    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TYPE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            sgn;
        logic            lo;   // lowest byte of its lane
        logic            hi;   // highest byte of its lane
    } t_lane_ctl;

    typedef struct packed {
        logic sum;  // carry of a + b
        logic ab;   // carry of ka - kb, set when ka >= kb
        logic ba;   // carry of kb - ka, set when kb >= ka
    } t_chain;

endpackage

`default_nettype wire

// ----- rtl/tvrc_in_if.sv -----
`default_nettype none

interface tvrc_in_if;
    import tvrc_pkg::*;

    logic              valid;
    logic              ready;
    t_word             data_word;
    logic [IDX_W-1:0]  word_index;
    logic              load_initial;

    modport source (output valid, data_word, word_index, load_initial, input ready);
    modport sink   (input valid, data_word, word_index, load_initial, output ready);
endinterface

`default_nettype wire

// ----- rtl/tvrc_out_if.sv -----
`default_nettype none

interface tvrc_out_if;
    import tvrc_pkg::*;

    logic              valid;
    logic              ready;
    t_word             result_word;
    logic [IDX_W-1:0]  result_index;

    modport source (output valid, result_word, result_index, input ready);
    modport sink   (input valid, result_word, result_index, output ready);
endinterface

`default_nettype wire

// ----- rtl/tvrc_ram.sv -----
`default_nettype none

module tvrc_ram #(
    parameter int  WIDTH = 64,
    parameter int  DEPTH = 256,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

`default_nettype wire

// ----- rtl/tvrc_lane.sv -----
`default_nettype none

module tvrc_lane (
    input  tvrc_pkg::t_byte     i_a,
    input  tvrc_pkg::t_byte     i_b,
    input  tvrc_pkg::t_lane_ctl i_ctl,
    input  tvrc_pkg::t_chain    i_chain,
    output tvrc_pkg::t_byte     o_sum,
    output tvrc_pkg::t_byte     o_logic,
    output tvrc_pkg::t_chain    o_chain
);
    import tvrc_pkg::*;

    t_byte      flip;
    t_byte      ka;
    t_byte      kb;
    logic       cin_sum;
    logic       cin_ab;
    logic       cin_ba;
    logic [8:0] sum_full;
    logic [8:0] ab_full;
    logic [8:0] ba_full;

    // signed lanes compare with the sign bit inverted
    assign flip = (i_ctl.sgn && i_ctl.hi) ? 8'h80 : 8'h00;
    assign ka   = i_a ^ flip;
    assign kb   = i_b ^ flip;

    // segment the chains at lane boundaries
    assign cin_sum = i_ctl.lo ? 1'b0 : i_chain.sum;
    assign cin_ab  = i_ctl.lo ? 1'b1 : i_chain.ab;
    assign cin_ba  = i_ctl.lo ? 1'b1 : i_chain.ba;

    assign sum_full = {1'b0, i_a} + {1'b0, i_b} + {8'b0, cin_sum};
    assign ab_full  = {1'b0, ka} + {1'b0, ~kb} + {8'b0, cin_ab};
    assign ba_full  = {1'b0, kb} + {1'b0, ~ka} + {8'b0, cin_ba};

    assign o_sum      = sum_full[7:0];
    assign o_chain.sum = sum_full[8];
    assign o_chain.ab  = ab_full[8];
    assign o_chain.ba  = ba_full[8];

    always_comb begin
        case (i_ctl.op)
            OP_AND:  o_logic = i_a & i_b;
            OP_OR:   o_logic = i_a | i_b;
            OP_XOR:  o_logic = i_a ^ i_b;
            default: o_logic = i_a;
        endcase
    end
endmodule

`default_nettype wire

// ----- rtl/tvrc_mul.sv -----
`default_nettype none

module tvrc_mul (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  tvrc_pkg::t_word             i_a,
    input  tvrc_pkg::t_word             i_b,
    input  logic [tvrc_pkg::WC_W-1:0]   i_wc,
    output tvrc_pkg::t_word             o_prod
);
    import tvrc_pkg::*;

    localparam int N16 = WORD_W / 16;

    t_word             r_p00;
    logic [HALF_W-1:0] r_p01;
    logic [HALF_W-1:0] r_p10;
    logic [HALF_W-1:0] r_p11;
    logic [15:0]       r_p16 [N16];
    t_byte             r_p8  [BYTES];
    logic [WC_W-1:0]   r_wc;

    t_word             n_p00;
    logic [HALF_W-1:0] n_p01;
    logic [HALF_W-1:0] n_p10;
    logic [HALF_W-1:0] n_p11;
    logic [15:0]       n_p16 [N16];
    t_byte             n_p8  [BYTES];

    // stage 1: partial products, 32x32 at most
    always_comb begin
        n_p00 = {{HALF_W{1'b0}}, i_a[HALF_W-1:0]} * {{HALF_W{1'b0}}, i_b[HALF_W-1:0]};
        n_p01 = i_a[HALF_W-1:0] * i_b[WORD_W-1:HALF_W];
        n_p10 = i_a[WORD_W-1:HALF_W] * i_b[HALF_W-1:0];
        n_p11 = i_a[WORD_W-1:HALF_W] * i_b[WORD_W-1:HALF_W];
        for (int i = 0; i < N16; i++) begin
            n_p16[i] = i_a[i*16 +: 16] * i_b[i*16 +: 16];
        end
        for (int i = 0; i < BYTES; i++) begin
            n_p8[i] = i_a[i*8 +: 8] * i_b[i*8 +: 8];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p00 <= n_p00;
            r_p01 <= n_p01;
            r_p10 <= n_p10;
            r_p11 <= n_p11;
            r_p16 <= n_p16;
            r_p8  <= n_p8;
            r_wc  <= i_wc;
        end
    end

    // stage 2: assemble the lane products
    always_comb begin
        o_prod = '0;
        case (r_wc)
            WC_64: begin
                o_prod = r_p00 + {r_p01 + r_p10, {HALF_W{1'b0}}};
            end
            WC_32: begin
                o_prod = {r_p11, r_p00[HALF_W-1:0]};
            end
            WC_16: begin
                for (int i = 0; i < N16; i++) begin
                    o_prod[i*16 +: 16] = r_p16[i];
                end
            end
            default: begin
                for (int i = 0; i < BYTES; i++) begin
                    o_prod[i*8 +: 8] = r_p8[i];
                end
            end
        endcase
    end
endmodule

`default_nettype wire

// ----- rtl/typed_vector_reduce_combiner.sv -----
// Channel  Dir  Payload                                 Handshake
// i_in     in   data_word, word_index, load_initial     valid / ready
// o_out    out  result_word, result_index               valid / ready
// i_cfg    in   i_cfg_idx, i_cfg_data                   i_cfg_we
//
// One request per cycle while ready stays high (hazards and o_out back-pressure drop it);
// results pass stage 1, stage 2 and the output register. A combine request whose index
// matches a request still in stage 1 (or held in stage 2) waits until that one writes back.
// Eight byte lanes chain into 8/16/32/64-bit lanes; products take both stages.
// Synchronous reset clears control and config; the accumulator RAM is not cleared.
// o_out back-pressure fills the output, stage 2 and stage 1 before ready drops.
`default_nettype none
`include "typed_vector_reduce_combiner_macros.svh"

module typed_vector_reduce_combiner (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [tvrc_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [tvrc_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    tvrc_in_if.sink                            i_in,
    tvrc_out_if.source                         o_out
);
    import tvrc_pkg::*;

    // configuration
    logic [OP_W-1:0]       r_op;
    logic [TYPE_W-1:0]     r_etype;
    logic [CNT_W-1:0]      r_count;
    logic [WC_W-1:0]       wc;
    logic                  sgn;
    logic [BYTE_IDX_W-1:0] seg_m;

    // stage 1
    logic              r_s1_vld;
    logic [ADDR_W-1:0] r_s1_addr;
    t_word             r_s1_data;
    logic              r_s1_load;

    // last write-back, covers read-during-write
    logic              r_wb_vld;
    logic [ADDR_W-1:0] r_wb_addr;
    t_word             r_wb_data;

    // stage 2
    logic              r_s2_vld;
    logic [ADDR_W-1:0] r_s2_addr;
    t_word             r_s2_a;
    t_word             r_s2_alu;
    logic [BYTES-1:0]  r_s2_keep;
    logic              r_s2_prod;
    t_word             n_s2_alu;
    logic [BYTES-1:0]  n_s2_keep;

    // output
    logic              r_out_vld;
    t_word             r_out_word;
    logic [ADDR_W-1:0] r_out_addr;

    logic              en_out;
    logic              en_s2;
    logic              en_s1;
    logic [ADDR_W-1:0] in_addr;
    logic              hazard;
    logic              in_rdy;
    logic              in_acc;
    t_word             ram_rd;
    logic              ram_we;
    t_word             s1_a;
    t_word             prod;
    t_word             n_res;

    t_lane_ctl ctl       [BYTES];
    t_chain    chain_in  [BYTES];
    t_chain    chain_out [BYTES];
    t_byte     sum_b     [BYTES];
    t_byte     lgc_b     [BYTES];

    function automatic t_byte alu_pick(
        input logic [OP_W-1:0] op,
        input t_byte           a,
        input t_byte           b,
        input t_byte           sum,
        input t_byte           lgc,
        input logic            lt,
        input logic            gt
    );
        case (op)
            OP_MIN:                alu_pick = lt ? b : a;
            OP_MAX:                alu_pick = gt ? b : a;
            OP_SUM:                alu_pick = sum;
            OP_AND, OP_OR, OP_XOR: alu_pick = lgc;
            default:               alu_pick = a;
        endcase
    endfunction

    assign wc    = r_etype[TYPE_W-1:1];
    assign sgn   = r_etype[0];
    assign seg_m = BYTE_IDX_W'(BYTES - 1) >> wc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op    <= OP_MIN;
            r_etype <= '0;
            r_count <= CNT_W'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_OP:    r_op    <= i_cfg_data[OP_W-1:0];
                CFG_TYPE:  r_etype <= i_cfg_data[TYPE_W-1:0];
                CFG_COUNT: r_count <= i_cfg_data[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // flow control
    assign en_out  = !r_out_vld || o_out.ready;
    assign en_s2   = !r_s2_vld || en_out;
    assign en_s1   = !r_s1_vld || en_s2;
    assign in_addr = i_in.word_index[ADDR_W-1:0];
    assign hazard  = !i_in.load_initial &&
                     ((r_s1_vld && (r_s1_addr == in_addr)) ||
                      (r_s2_vld && !en_out && (r_s2_addr == in_addr)));
    assign in_rdy  = en_s1 && !hazard;
    assign in_acc  = i_in.valid && in_rdy;
    assign ram_we  = r_s2_vld && en_out;

    assign i_in.ready = in_rdy;

    tvrc_ram #(
        .WIDTH (WORD_W),
        .DEPTH (WORDS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_s2_addr),
        .i_wdata (n_res),
        .i_re    (in_acc),
        .i_raddr (in_addr),
        .o_rdata (ram_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (en_s1) begin
            r_s1_vld <= in_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_addr <= in_addr;
            r_s1_data <= i_in.data_word;
            r_s1_load <= i_in.load_initial;
        end
    end

    assign s1_a = (r_wb_vld && (r_wb_addr == r_s1_addr)) ? r_wb_data : ram_rd;

    // byte lanes
    assign chain_in[0] = '0;

    for (genvar g = 0; g < BYTES; g++) begin : g_lane
        if (g > 0) begin : g_chain
            assign chain_in[g] = chain_out[g-1];
        end

        assign ctl[g] = '{
            op:  r_op,
            sgn: sgn,
            lo:  ((BYTE_IDX_W'(g) & seg_m) == '0),
            hi:  ((BYTE_IDX_W'(g) & seg_m) == seg_m)
        };

        tvrc_lane u_lane (
            .i_a     (s1_a[g*8 +: 8]),
            .i_b     (r_s1_data[g*8 +: 8]),
            .i_ctl   (ctl[g]),
            .i_chain (chain_in[g]),
            .o_sum   (sum_b[g]),
            .o_logic (lgc_b[g]),
            .o_chain (chain_out[g])
        );
    end

    tvrc_mul u_mul (
        .i_clk  (i_clk),
        .i_en   (en_s2),
        .i_a    (s1_a),
        .i_b    (r_s1_data),
        .i_wc   (wc),
        .o_prod (prod)
    );

    // merge: lane compare flags from the top byte, element range mask
    always_comb begin
        logic [BYTE_IDX_W-1:0] hi_j;
        logic [BYTE_IDX_W-1:0] lane_k;
        logic [CNT_W-1:0]      elem;
        logic                  lt;
        logic                  gt;
        n_s2_alu  = '0;
        n_s2_keep = '0;
        for (int j = 0; j < BYTES; j++) begin
            hi_j   = BYTE_IDX_W'(j) | seg_m;
            lane_k = BYTE_IDX_W'(j) >> (WC_W'(BYTE_IDX_W) - wc);
            elem   = (CNT_W'(r_s1_addr) << wc) | CNT_W'(lane_k);
            lt     = !chain_out[hi_j].ba;
            gt     = !chain_out[hi_j].ab;
            n_s2_keep[j] = r_s1_load || (elem < r_count);
            n_s2_alu[j*8 +: 8] = r_s1_load ? r_s1_data[j*8 +: 8] :
                alu_pick(r_op, s1_a[j*8 +: 8], r_s1_data[j*8 +: 8],
                         sum_b[j], lgc_b[j], lt, gt);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else if (en_s2) begin
            r_s2_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_s2) begin
            r_s2_addr <= r_s1_addr;
            r_s2_a    <= s1_a;
            r_s2_alu  <= n_s2_alu;
            r_s2_keep <= n_s2_keep;
            r_s2_prod <= !r_s1_load && (r_op == OP_PROD);
        end
    end

    always_comb begin
        n_res = '0;
        for (int j = 0; j < BYTES; j++) begin
            n_res[j*8 +: 8] = !r_s2_keep[j] ? r_s2_a[j*8 +: 8] :
                              r_s2_prod     ? prod[j*8 +: 8]   : r_s2_alu[j*8 +: 8];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
            r_wb_vld  <= 1'b0;
        end else begin
            if (en_out) begin
                r_out_vld <= r_s2_vld;
            end
            if (ram_we) begin
                r_wb_vld <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ram_we) begin
            r_out_word <= n_res;
            r_out_addr <= r_s2_addr;
            r_wb_addr  <= r_s2_addr;
            r_wb_data  <= n_res;
        end
    end

    assign o_out.valid        = r_out_vld;
    assign o_out.result_word  = r_out_word;
    assign o_out.result_index = IDX_W'(r_out_addr);

    // a combine in stage 1 never depends on the entry still held in stage 2
    `TVRC_ASSERT_IMP(a_no_raw_pair, i_clk, i_rst_n, r_s1_vld && !r_s1_load && r_s2_vld, r_s1_addr != r_s2_addr)
    `TVRC_ASSERT_NEXT(a_wb_to_out, i_clk, i_rst_n, ram_we, r_out_vld && (r_out_addr == $past(r_s2_addr)) && (r_wb_data == r_out_word))
    `TVRC_ASSERT_NEXT(a_acc_to_s1, i_clk, i_rst_n, in_acc, r_s1_vld && (r_s1_addr == $past(in_addr)))
endmodule

`default_nettype wire

// ----- dv/tvrc_checker.sv -----
`default_nettype none

module tvrc_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [tvrc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [tvrc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    tvrc_in_if                              i_in,
    tvrc_out_if                             i_res,
    output int                              o_fail_count,
    output int                              o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    import tvrc_pkg::*;

    typedef struct packed {
        t_word            word;
        logic [IDX_W-1:0] index;
    } t_update;

    t_word             acc_mem [WORDS];
    logic [OP_W-1:0]   cur_op;
    logic [TYPE_W-1:0] cur_type;
    logic [CNT_W-1:0]  cur_count;
    t_update           update_q [$];
    int                fails = 0;

    // lane-wise merge of an incoming word into the stored word at index widx
    function automatic t_word reduce_word(input t_word stored, input t_word incoming,
                                          input int unsigned widx);
        int unsigned lane_bits;
        int unsigned lane_cnt;
        int unsigned k;
        t_word       mask;
        t_word       sbit;
        t_word       a;
        t_word       b;
        t_word       r;
        t_word       merged;
        case (cur_type[2:1])
            WC_64:   lane_bits = 64;
            WC_32:   lane_bits = 32;
            WC_16:   lane_bits = 16;
            default: lane_bits = 8;
        endcase
        lane_cnt = WORD_W / lane_bits;
        mask     = (lane_bits == WORD_W) ? '1 : ((t_word'(1) << lane_bits) - t_word'(1));
        sbit     = cur_type[0] ? (t_word'(1) << (lane_bits - 1)) : '0;
        merged   = '0;
        for (k = 0; k < lane_cnt; k++) begin
            a = (stored >> (k * lane_bits)) & mask;
            b = (incoming >> (k * lane_bits)) & mask;
            case (cur_op)
                OP_MIN:  r = ((b ^ sbit) < (a ^ sbit)) ? b : a;
                OP_MAX:  r = ((b ^ sbit) > (a ^ sbit)) ? b : a;
                OP_SUM:  r = (a + b) & mask;
                OP_PROD: r = (a * b) & mask;
                OP_AND:  r = a & b;
                OP_OR:   r = a | b;
                OP_XOR:  r = a ^ b;
                default: r = a;
            endcase
            // elements at or past the count keep their stored value
            if (widx * lane_cnt + k >= cur_count) r = a;
            merged |= (r & mask) << (k * lane_bits);
        end
        return merged;
    endfunction

    always @(posedge i_clk) begin
        t_update     want;
        t_word       nxt;
        int unsigned addr;
        if (!i_rst_n) begin
            cur_op    = OP_MIN;
            cur_type  = {WC_64, 1'b0};
            cur_count = CNT_W'(1);
            update_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_OP:    cur_op    = i_cfg_data[OP_W-1:0];
                    CFG_TYPE:  cur_type  = i_cfg_data[TYPE_W-1:0];
                    CFG_COUNT: cur_count = i_cfg_data[CNT_W-1:0];
                    default: ;
                endcase
            end
            if (i_res.valid && i_res.ready) begin
                if (update_q.size() == 0) begin
                    $error("unexpected result: index %0d word %h",
                           i_res.result_index, i_res.result_word);
                    fails++;
                end else begin
                    want = update_q.pop_front();
                    if (i_res.result_word !== want.word) begin
                        $error("result_word mismatch: expected %h, got %h",
                               want.word, i_res.result_word);
                        fails++;
                    end
                    if (i_res.result_index !== want.index) begin
                        $error("result_index mismatch: expected %0d, got %0d",
                               want.index, i_res.result_index);
                        fails++;
                    end
                end
            end
            if (i_in.valid && i_in.ready) begin
                addr = i_in.word_index % WORDS;
                if (i_in.load_initial)
                    nxt = i_in.data_word;
                else
                    nxt = reduce_word(acc_mem[addr], i_in.data_word, addr);
                acc_mem[addr] = nxt;
                update_q.push_back('{word: nxt, index: IDX_W'(addr)});
            end
        end
        o_fail_count  <= fails;
        o_outstanding <= update_q.size();
    end

endmodule

`default_nettype wire

// ----- dv/tb.sv -----
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tvrc_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;
    localparam logic [OP_W-1:0] OP_SEQ [8] = '{OP_MIN, OP_MAX, OP_SUM, OP_PROD,
                                               OP_AND, OP_OR, OP_XOR, OP_UNUSED};
    localparam logic [TYPE_W-1:0] TYPE_SEQ [8] = '{{WC_64, 1'b0}, {WC_64, 1'b1},
                                                   {WC_32, 1'b0}, {WC_32, 1'b1},
                                                   {WC_16, 1'b0}, {WC_16, 1'b1},
                                                   {WC_8,  1'b0}, {WC_8,  1'b1}};
    localparam int unsigned COUNT_MAX = 2048;
    localparam t_word PAT_A = 64'h80FF_7F01_8000_7FFF;
    localparam t_word PAT_B = 64'h7F01_80FF_FFFF_0001;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    tvrc_in_if  in_ch ();
    tvrc_out_if out_ch ();

    int               fail_count;
    int               outstanding;
    bit               steady;
    bit               loaded [WORDS];
    logic [IDX_W-1:0] hot_idx [4];
    int               n_loads = 0;
    int               n_combines = 0;
    int               n_settings = 0;

    typed_vector_reduce_combiner u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    tvrc_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_in          (in_ch),
        .i_res         (out_ch),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #2_000_000;
        $display("timeout: requests still pending");
        $display("Test completed with failures");
        $finish;
    end

    // result side: random stall before each result, none while steady
    initial begin
        int gap;
        out_ch.ready <= 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            gap = steady ? 0 : $urandom_range(0, 19);
            if (gap != 0) begin
                out_ch.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!out_ch.valid);
        end
    end

    task automatic send_word(input t_word w, input logic [IDX_W-1:0] idx, input logic ld);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 19);
        if (gap != 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.data_word    <= w;
        in_ch.word_index   <= idx;
        in_ch.load_initial <= ld;
        do @(posedge i_clk); while (!in_ch.ready);
        if (ld) begin
            loaded[idx] = 1'b1;
            n_loads++;
        end else begin
            n_combines++;
        end
    endtask

    // hold off requests until every result is back
    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
    endtask

    task automatic set_config(input logic [OP_W-1:0] op, input logic [TYPE_W-1:0] typ,
                              input int unsigned cnt);
        drain();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_OP;
        i_cfg_data <= CFG_DATA_W'(op);
        @(posedge i_clk);
        i_cfg_idx  <= CFG_TYPE;
        i_cfg_data <= CFG_DATA_W'(typ);
        @(posedge i_clk);
        i_cfg_idx  <= CFG_COUNT;
        i_cfg_data <= CFG_DATA_W'(cnt);
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        n_settings++;
    endtask

    task automatic send_random();
        logic [IDX_W-1:0] idx;
        logic             ld;
        t_word            w;
        // half of the time one of four hot indexes, so combines chain on one entry
        if ($urandom_range(0, 1) == 0)
            idx = hot_idx[$urandom_range(0, 3)];
        else
            idx = IDX_W'($urandom_range(0, 255));
        ld = !loaded[idx] || ($urandom_range(0, 4) == 0);
        case ($urandom_range(0, 9))
            0:       w = '0;
            1:       w = '1;
            2:       w = {8{8'h80}};
            3:       w = {8{8'h7F}};
            4:       w = {4{16'h8000}} | t_word'($urandom_range(0, 255));
            default: w = {$urandom, $urandom};
        endcase
        send_word(w, idx, ld);
    endtask

    initial begin
        logic [OP_W-1:0]   op;
        logic [TYPE_W-1:0] typ;
        int unsigned       cnt;
        i_rst_n            <= 1'b0;
        i_cfg_we           <= 1'b0;
        i_cfg_idx          <= CFG_OP;
        i_cfg_data         <= '0;
        in_ch.valid        <= 1'b0;
        in_ch.data_word    <= '0;
        in_ch.word_index   <= '0;
        in_ch.load_initial <= 1'b0;
        steady = 1'b1;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: min over one u64 element
        send_word('1, 8'd0, 1'b1);
        send_word('0, 8'd0, 1'b0);

        // every operation, every lane format, full element count
        for (int i = 0; i < 8; i++) begin
            set_config(OP_SEQ[i], TYPE_SEQ[i], COUNT_MAX);
            send_word(PAT_A, 8'd255, 1'b1);
            send_word(PAT_B, 8'd255, 1'b0);
        end

        // lanes past the count stay untouched
        set_config(OP_SUM, {WC_8, 1'b0}, 3);
        send_word('1, 8'd0, 1'b1);
        send_word('1, 8'd0, 1'b0);
        send_word(PAT_A, 8'd1, 1'b1);
        send_word(PAT_B, 8'd1, 1'b0);

        for (int p = 0; p < 10; p++) begin
            steady = ($urandom_range(0, 3) == 0);
            op  = ($urandom_range(0, 9) == 0) ? OP_UNUSED : OP_SEQ[$urandom_range(0, 6)];
            typ = TYPE_SEQ[$urandom_range(0, 7)];
            case (p)
                0: cnt = COUNT_MAX;
                1: cnt = 1;
                default: begin
                    case ($urandom_range(0, 2))
                        0:       cnt = $urandom_range(1, 64);
                        1:       cnt = $urandom_range(1, COUNT_MAX);
                        default: cnt = COUNT_MAX;
                    endcase
                end
            endcase
            set_config(op, typ, cnt);
            for (int h = 0; h < 4; h++) hot_idx[h] = IDX_W'($urandom_range(0, 255));
            repeat (50) send_random();
        end

        drain();
        repeat (8) @(posedge i_clk);
        $display("Covered %0d requests (%0d loads, %0d combines) under %0d register settings",
                 n_loads + n_combines, n_loads, n_combines, n_settings);
        if (fail_count == 0 && outstanding == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

`default_nettype wire
